[rtl/keyboard_scan_code_translator_defines.svh]
// Assertion macros shared by the translator's RTL files.
`ifndef KEYBOARD_SCAN_CODE_TRANSLATOR_DEFINES_SVH
`define KEYBOARD_SCAN_CODE_TRANSLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KBD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KBD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The expression must never be true.
`define KBD_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

[rtl/kbd_pkg.sv]
`default_nettype none

package kbd_pkg;

   // Entry classes of the key table.
   typedef enum logic [2:0] {
      CLS_PLAIN = 3'd0,
      CLS_LIT   = 3'd1,
      CLS_CYR   = 3'd2,
      CLS_ESC   = 3'd3,
      CLS_SPEC  = 3'd4,
      CLS_DIG   = 3'd5,
      CLS_CTL   = 3'd6,
      CLS_KPAD  = 3'd7
   } kbd_class_type;

   // Special key codes, held in the character field of a special entry.
   localparam logic [6:0] SP_FIX  = 7'd0;
   localparam logic [6:0] SP_ROFF = 7'd1;
   localparam logic [6:0] SP_RPT  = 7'd2;
   localparam logic [6:0] SP_CTRL = 7'd3;
   localparam logic [6:0] SP_RUS  = 7'd4;
   localparam logic [6:0] SP_SHF  = 7'd5;
   localparam logic [6:0] SP_SCRL = 7'd6;
   localparam logic [6:0] SP_HOLD = 7'd7;
   localparam logic [6:0] SP_PRSC = 7'd8;

   // Indicator bits.
   localparam logic [4:0] IND_WAIT = 5'b00001;
   localparam logic [4:0] IND_FIX  = 5'b00100;
   localparam logic [4:0] IND_STOP = 5'b01000;
   localparam logic [4:0] IND_RUS  = 5'b10000;

   // Character constants.
   localparam logic [7:0] CHR_ESC      = 8'o033;
   localparam logic [7:0] CHR_GS       = 8'o035;
   localparam logic [7:0] CHR_SO       = 8'o016;
   localparam logic [7:0] CHR_SI       = 8'o017;
   localparam logic [7:0] CHR_ALL_ONES = 8'o377;
   localparam logic [7:0] CHR_CASE_BIT = 8'o040;
   localparam logic [7:0] CHR_DIG_BIT  = 8'o020;
   localparam logic [7:0] CHR_CTL_MASK = 8'o037;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_CHAR    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_CHAR   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAW_MODE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESTART_ONLY = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALT_KEYPAD   = 3'd4;

   localparam logic [7:0] STOP_CHAR_RESET  = 8'd19;
   localparam logic [7:0] START_CHAR_RESET = 8'd17;

   typedef struct packed {
      logic [7:0] stop_char;
      logic [7:0] start_char;
      logic       raw_mode;
      logic       restart_on_start_only;
      logic       alt_keypad;
   } kbd_cfg_type;

   // One classified scan code on its way from the front to the back.
   typedef struct packed {
      logic       pre_valid;
      logic [7:0] pre_char;
      logic       main_valid;
      logic [7:0] main_char;
      logic [4:0] indicators;
      logic       bell_request;
      logic       reset_request;
      logic       print_start;
      logic       print_positive;
   } kbd_job_type;

   typedef struct packed {
      logic          valid;
      kbd_class_type cls;
      logic [6:0]    ch;
   } kbd_entry_type;

   function automatic kbd_entry_type kbd_ent(input kbd_class_type cls, input logic [6:0] ch);
      kbd_entry_type e;
      e.valid = 1'b1;
      e.cls   = cls;
      e.ch    = ch;
      return e;
   endfunction

   // Key table: codes 86 (octal 0126) through 253; everything else is empty.
   function automatic kbd_entry_type kbd_lookup(input logic [7:0] code);
      kbd_entry_type e;
      e.valid = 1'b0;
      e.cls   = CLS_PLAIN;
      e.ch    = 7'h00;
      case (code)
         8'd86:  e = kbd_ent(CLS_SPEC, SP_HOLD);
         8'd87:  e = kbd_ent(CLS_SPEC, SP_PRSC);
         8'd88:  e = kbd_ent(CLS_ESC, 7'h46);
         8'd89:  e = kbd_ent(CLS_ESC, 7'h47);
         8'd90:  e = kbd_ent(CLS_ESC, 7'h48);
         8'd100: e = kbd_ent(CLS_ESC, 7'h49);
         8'd101: e = kbd_ent(CLS_ESC, 7'h4A);
         8'd102: e = kbd_ent(CLS_ESC, 7'h4B);
         8'd103: e = kbd_ent(CLS_ESC, 7'h4C);
         8'd104: e = kbd_ent(CLS_ESC, 7'h4D);
         8'd113: e = kbd_ent(CLS_ESC, 7'h4E);
         8'd114: e = kbd_ent(CLS_ESC, 7'h4F);
         8'd115: e = kbd_ent(CLS_ESC, 7'h50);
         8'd116: e = kbd_ent(CLS_ESC, 7'h51);
         8'd124: e = kbd_ent(CLS_ESC, 7'h52);
         8'd125: e = kbd_ent(CLS_ESC, 7'h53);
         8'd128: e = kbd_ent(CLS_ESC, 7'h54);
         8'd129: e = kbd_ent(CLS_ESC, 7'h55);
         8'd130: e = kbd_ent(CLS_ESC, 7'h56);
         8'd131: e = kbd_ent(CLS_ESC, 7'h57);
         8'd138: e = kbd_ent(CLS_ESC, 7'h58);
         8'd139: e = kbd_ent(CLS_ESC, 7'h59);
         8'd140: e = kbd_ent(CLS_ESC, 7'h5A);
         8'd141: e = kbd_ent(CLS_ESC, 7'h40);
         8'd142: e = kbd_ent(CLS_ESC, 7'h30);
         8'd143: e = kbd_ent(CLS_ESC, 7'h31);
         8'd146: e = kbd_ent(CLS_KPAD, 7'h30);
         8'd148: e = kbd_ent(CLS_KPAD, 7'h2E);
         8'd149: e = kbd_ent(CLS_LIT, 7'h0A);
         8'd150: e = kbd_ent(CLS_KPAD, 7'h31);
         8'd151: e = kbd_ent(CLS_KPAD, 7'h32);
         8'd152: e = kbd_ent(CLS_KPAD, 7'h33);
         8'd153: e = kbd_ent(CLS_KPAD, 7'h34);
         8'd154: e = kbd_ent(CLS_KPAD, 7'h35);
         8'd155: e = kbd_ent(CLS_KPAD, 7'h36);
         8'd156: e = kbd_ent(CLS_KPAD, 7'h2C);
         8'd157: e = kbd_ent(CLS_KPAD, 7'h37);
         8'd158: e = kbd_ent(CLS_KPAD, 7'h38);
         8'd159: e = kbd_ent(CLS_KPAD, 7'h39);
         8'd160: e = kbd_ent(CLS_KPAD, 7'h2D);
         8'd161: e = kbd_ent(CLS_ESC, 7'h32);
         8'd162: e = kbd_ent(CLS_ESC, 7'h33);
         8'd163: e = kbd_ent(CLS_ESC, 7'h34);
         8'd164: e = kbd_ent(CLS_ESC, 7'h35);
         8'd167: e = kbd_ent(CLS_ESC, 7'h36);
         8'd168: e = kbd_ent(CLS_ESC, 7'h37);
         8'd169: e = kbd_ent(CLS_ESC, 7'h38);
         8'd170: e = kbd_ent(CLS_ESC, 7'h39);
         8'd174: e = kbd_ent(CLS_SPEC, SP_SHF);
         8'd175: e = kbd_ent(CLS_SPEC, SP_CTRL);
         8'd176: e = kbd_ent(CLS_SPEC, SP_FIX);
         8'd177: e = kbd_ent(CLS_SPEC, SP_SCRL);
         8'd178: e = kbd_ent(CLS_SPEC, SP_RUS);
         8'd179: e = kbd_ent(CLS_SPEC, SP_ROFF);
         8'd180: e = kbd_ent(CLS_SPEC, SP_RPT);
         8'd188: e = kbd_ent(CLS_LIT, 7'h7F);
         8'd189: e = kbd_ent(CLS_LIT, 7'h0D);
         8'd190: e = kbd_ent(CLS_LIT, 7'h09);
         8'd191: e = kbd_ent(CLS_DIG, 7'h2B);
         8'd192: e = kbd_ent(CLS_DIG, 7'h21);
         8'd193: e = kbd_ent(CLS_PLAIN, 7'h6A);
         8'd194: e = kbd_ent(CLS_PLAIN, 7'h66);
         8'd195: e = kbd_ent(CLS_PLAIN, 7'h71);
         8'd196: e = kbd_ent(CLS_LIT, 7'h08);
         8'd197: e = kbd_ent(CLS_DIG, 7'h22);
         8'd198: e = kbd_ent(CLS_PLAIN, 7'h63);
         8'd199: e = kbd_ent(CLS_PLAIN, 7'h79);
         8'd200: e = kbd_ent(CLS_PLAIN, 7'h7E);
         8'd201: e = kbd_ent(CLS_ESC, 7'h42);
         8'd202: e = kbd_ent(CLS_DIG, 7'h3F);
         8'd203: e = kbd_ent(CLS_DIG, 7'h23);
         8'd204: e = kbd_ent(CLS_PLAIN, 7'h75);
         8'd205: e = kbd_ent(CLS_PLAIN, 7'h77);
         8'd206: e = kbd_ent(CLS_PLAIN, 7'h73);
         8'd208: e = kbd_ent(CLS_DIG, 7'h24);
         8'd209: e = kbd_ent(CLS_PLAIN, 7'h6B);
         8'd210: e = kbd_ent(CLS_PLAIN, 7'h61);
         8'd211: e = kbd_ent(CLS_PLAIN, 7'h6D);
         8'd212: e = kbd_ent(CLS_LIT, 7'h20);
         8'd214: e = kbd_ent(CLS_DIG, 7'h25);
         8'd215: e = kbd_ent(CLS_PLAIN, 7'h65);
         8'd216: e = kbd_ent(CLS_PLAIN, 7'h70);
         8'd217: e = kbd_ent(CLS_PLAIN, 7'h69);
         8'd219: e = kbd_ent(CLS_DIG, 7'h26);
         8'd220: e = kbd_ent(CLS_PLAIN, 7'h6E);
         8'd221: e = kbd_ent(CLS_PLAIN, 7'h72);
         8'd222: e = kbd_ent(CLS_PLAIN, 7'h74);
         8'd224: e = kbd_ent(CLS_DIG, 7'h27);
         8'd225: e = kbd_ent(CLS_PLAIN, 7'h67);
         8'd226: e = kbd_ent(CLS_PLAIN, 7'h6F);
         8'd227: e = kbd_ent(CLS_PLAIN, 7'h78);
         8'd229: e = kbd_ent(CLS_DIG, 7'h28);
         8'd230: e = kbd_ent(CLS_PLAIN, 7'h7B);
         8'd231: e = kbd_ent(CLS_PLAIN, 7'h6C);
         8'd232: e = kbd_ent(CLS_PLAIN, 7'h62);
         8'd234: e = kbd_ent(CLS_DIG, 7'h29);
         8'd235: e = kbd_ent(CLS_PLAIN, 7'h7D);
         8'd236: e = kbd_ent(CLS_PLAIN, 7'h64);
         8'd237: e = kbd_ent(CLS_PLAIN, 7'h60);
         8'd239: e = kbd_ent(CLS_LIT, 7'h30);
         8'd240: e = kbd_ent(CLS_PLAIN, 7'h7A);
         8'd241: e = kbd_ent(CLS_CTL, 7'h5F);
         8'd242: e = kbd_ent(CLS_PLAIN, 7'h76);
         8'd243: e = kbd_ent(CLS_DIG, 7'h3C);
         8'd245: e = kbd_ent(CLS_ESC, 7'h41);
         8'd246: e = kbd_ent(CLS_PLAIN, 7'h68);
         8'd247: e = kbd_ent(CLS_DIG, 7'h3E);
         8'd249: e = kbd_ent(CLS_DIG, 7'h3D);
         8'd250: e = kbd_ent(CLS_DIG, 7'h2A);
         8'd251: e = kbd_ent(CLS_PLAIN, 7'h7C);
         8'd252: e = kbd_ent(CLS_ESC, 7'h43);
         8'd253: e = kbd_ent(CLS_CYR, 7'h5F);
         default: e.valid = 1'b0;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

[rtl/kbd_ifs.sv]
`default_nettype none

// Scan code channel.
interface kbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] scan_code;
   logic       output_stopped;
   logic       queue_over_half;
   logic       print_waiting;

   modport source (output valid, output scan_code, output output_stopped,
                   output queue_over_half, output print_waiting, input ready);
   modport sink   (input valid, input scan_code, input output_stopped,
                   input queue_over_half, input print_waiting, output ready);
endinterface

// Result channel.
interface kbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       char_valid;
   logic       last;
   logic [4:0] indicators;
   logic       bell_request;
   logic       reset_request;
   logic       print_start;
   logic       print_positive;

   modport source (output valid, output char_out, output char_valid, output last,
                   output indicators, output bell_request, output reset_request,
                   output print_start, output print_positive, input ready);
   modport sink   (input valid, input char_out, input char_valid, input last,
                   input indicators, input bell_request, input reset_request,
                   input print_start, input print_positive, output ready);
endinterface

`default_nettype wire

[rtl/kbd_front.sv]
`default_nettype none

module kbd_front import kbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  kbd_cfg_type cfg,
   kbd_req_if.sink     req_ch,
   input  logic        queue_full,
   output logic        job_push,
   output kbd_job_type job
);

   typedef enum logic [1:0] {
      PATH_NONE,
      PATH_COMMON,
      PATH_SKIP
   } path_type;

   logic          cyr_ff, cyr_in;
   logic          ctrl_ff, ctrl_in;
   logic          fix_ff, fix_in;
   logic [1:0]    shift_ff, shift_in;
   logic [2:0]    scroll_ff, scroll_in;
   logic [7:0]    prev_char_ff, prev_char_in;
   logic [7:0]    prev_prefix_ff, prev_prefix_in;
   logic [4:0]    ind_ff, ind_in;

   kbd_entry_type ent;
   path_type      path;
   logic [7:0]    c1;
   logic          pre_valid;
   logic [7:0]    pre_char;
   logic          bell, rst_req, pstart, ppos;
   logic          stopped;
   logic          accept;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;
   assign stopped      = req_ch.output_stopped;
   assign ent          = kbd_lookup(req_ch.scan_code);

   // Classify the scan code and work out the state that it leaves behind.
   always_comb begin
      cyr_in         = cyr_ff;
      ctrl_in        = ctrl_ff;
      fix_in         = fix_ff;
      shift_in       = shift_ff;
      scroll_in      = scroll_ff;
      prev_char_in   = prev_char_ff;
      prev_prefix_in = prev_prefix_ff;
      ind_in         = ind_ff;
      path           = PATH_NONE;
      c1             = {1'b0, ent.ch};
      pre_valid      = 1'b0;
      pre_char       = 8'h00;
      bell           = 1'b0;
      rst_req        = 1'b0;
      pstart         = 1'b0;
      ppos           = 1'b0;

      if (ent.valid) begin
         case (ent.cls)
            CLS_CYR: begin
               if (!cyr_ff) begin
                  prev_char_in   = 8'h00;
                  prev_prefix_in = 8'h00;
               end else begin
                  path = PATH_COMMON;
               end
            end
            CLS_LIT: begin
               path = PATH_COMMON;
            end
            CLS_KPAD: begin
               if (!cfg.alt_keypad) begin
                  path = PATH_COMMON;
               end else begin
                  prev_prefix_in = CHR_GS;
                  pre_valid      = 1'b1;
                  pre_char       = CHR_GS;
                  path           = PATH_SKIP;
               end
            end
            CLS_ESC: begin
               prev_prefix_in = CHR_ESC;
               pre_valid      = 1'b1;
               pre_char       = CHR_ESC;
               path           = PATH_SKIP;
            end
            CLS_DIG: begin
               if (shift_ff == 2'd0) c1 = c1 ^ CHR_DIG_BIT;
               path = PATH_COMMON;
            end
            CLS_PLAIN: begin
               if (shift_ff != 2'd0) c1 = c1 ^ CHR_CASE_BIT;
               if (fix_ff) c1 = c1 ^ CHR_CASE_BIT;
               if (ctrl_ff) c1 = c1 & CHR_CTL_MASK;
               path = PATH_COMMON;
            end
            CLS_CTL: begin
               if (ctrl_ff) c1 = c1 & CHR_CTL_MASK;
               path = PATH_COMMON;
            end
            CLS_SPEC: begin
               case (ent.ch)
                  SP_SHF: begin
                     shift_in = (shift_ff >= 2'd2) ? 2'd2 : shift_ff + 2'd1;
                  end
                  SP_CTRL: begin
                     shift_in = 2'd0;
                     ctrl_in  = 1'b1;
                  end
                  SP_ROFF: begin
                     if (ctrl_ff) begin
                        ctrl_in = 1'b0;
                     end else if (shift_ff != 2'd0) begin
                        shift_in = shift_ff - 2'd1;
                     end
                  end
                  SP_FIX: begin
                     fix_in = !fix_ff;
                     if (!fix_ff) ind_in = ind_ff | IND_FIX;
                     else ind_in = ind_ff & ~IND_FIX;
                  end
                  SP_RUS: begin
                     cyr_in         = !cyr_ff;
                     pre_valid      = 1'b1;
                     pre_char       = cyr_ff ? CHR_SI : CHR_SO;
                     ind_in         = cyr_ff ? (ind_ff & ~IND_RUS) : (ind_ff | IND_RUS);
                     prev_char_in   = 8'h00;
                     prev_prefix_in = 8'h00;
                  end
                  SP_RPT: begin
                     if (!req_ch.queue_over_half) begin
                        if (prev_prefix_ff != 8'h00) begin
                           pre_valid = 1'b1;
                           pre_char  = prev_prefix_ff;
                        end
                        if (prev_char_ff != 8'h00) begin
                           c1   = prev_char_ff;
                           path = PATH_SKIP;
                        end
                     end
                  end
                  SP_SCRL: begin
                     // The scroll level is a signed value kept within -1..3.
                     if (shift_ff != 2'd0 || ctrl_ff) begin
                        if (scroll_ff[2] || scroll_ff == 3'd0) scroll_in = 3'b111;
                        else scroll_in = scroll_ff - 3'd1;
                        if (stopped) begin
                           c1   = cfg.start_char;
                           path = PATH_COMMON;
                        end
                     end else begin
                        if (scroll_ff == 3'd3) begin
                           scroll_in = 3'd3;
                           if (!stopped) begin
                              c1   = cfg.stop_char;
                              path = PATH_COMMON;
                           end
                        end else if (scroll_ff == 3'b100 || scroll_ff == 3'b101) begin
                           scroll_in = 3'b111;
                        end else begin
                           scroll_in = scroll_ff + 3'd1;
                        end
                     end
                  end
                  SP_HOLD: begin
                     if (ctrl_ff && shift_ff != 2'd0) begin
                        rst_req = 1'b1;
                        bell    = 1'b1;
                     end else begin
                        c1 = stopped ? cfg.start_char : cfg.stop_char;
                        if (c1 != 8'h00 && c1 != CHR_ALL_ONES) path = PATH_COMMON;
                     end
                  end
                  default: begin
                     // Print screen key.
                     if (req_ch.print_waiting) begin
                        pstart = 1'b1;
                        ppos   = ctrl_ff || shift_ff != 2'd0;
                        ind_in = ind_ff | IND_WAIT;
                     end
                  end
               endcase
            end
            default: path = PATH_NONE;
         endcase
      end

      // Flow control indicators for an emitted character.
      if (path == PATH_COMMON) begin
         prev_prefix_in = 8'h00;
         if (c1 == cfg.stop_char && c1 != 8'h00 && c1 != CHR_ALL_ONES &&
             !cfg.raw_mode && !stopped) begin
            ind_in = ind_in | IND_STOP;
         end
      end
      if (path != PATH_NONE) begin
         prev_char_in = c1;
         if (!cfg.raw_mode && stopped &&
             (!cfg.restart_on_start_only || c1 == cfg.start_char)) begin
            ind_in = ind_in & ~(IND_STOP | IND_WAIT);
         end
      end
   end

   // Hand the classified word to the queue.
   always_comb begin
      job_push           = accept;
      job.pre_valid      = pre_valid;
      job.pre_char       = pre_char;
      job.main_valid     = path != PATH_NONE;
      job.main_char      = c1;
      job.indicators     = ind_in;
      job.bell_request   = bell;
      job.reset_request  = rst_req;
      job.print_start    = pstart;
      job.print_positive = ppos;
   end

   // Keyboard state advances with each accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         cyr_ff         <= 1'b0;
         ctrl_ff        <= 1'b0;
         fix_ff         <= 1'b0;
         shift_ff       <= 2'd0;
         scroll_ff      <= 3'd0;
         prev_char_ff   <= 8'h00;
         prev_prefix_ff <= 8'h00;
         ind_ff         <= 5'd0;
      end else if (accept) begin
         cyr_ff         <= cyr_in;
         ctrl_ff        <= ctrl_in;
         fix_ff         <= fix_in;
         shift_ff       <= shift_in;
         scroll_ff      <= scroll_in;
         prev_char_ff   <= prev_char_in;
         prev_prefix_ff <= prev_prefix_in;
         ind_ff         <= ind_in;
      end
   end

endmodule

`default_nettype wire

[rtl/kbd_queue.sv]
`default_nettype none
`include "keyboard_scan_code_translator_defines.svh"

module kbd_queue import kbd_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  kbd_job_type push_job,
   input  logic        pop,
   output logic        full,
   output logic        head_valid,
   output kbd_job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   kbd_job_type      mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full       = cnt_ff == CNT_W'(DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_job   = mem_ff[rd_ptr_ff];

   // Pointer wrap and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) cnt_in = cnt_ff + CNT_W'(1);
      else if (pop && !push) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `KBD_ASSERT_IMP(a_no_push_full, clock, reset, push, !full, "push into a full queue")
   `KBD_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, head_valid, "pop from an empty queue")
   `KBD_ASSERT_NXT(a_cnt_drop, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - CNT_W'(1), "count did not drop on pop")

endmodule

`default_nettype wire

[rtl/kbd_back.sv]
`default_nettype none
`include "keyboard_scan_code_translator_defines.svh"

module kbd_back import kbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  kbd_job_type head_job,
   output logic        pop,
   kbd_rsp_if.source   rsp_ch
);

   typedef enum logic {
      PH_FIRST,
      PH_SECOND
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       cv_ff, cv_in;
   logic       last_ff, last_in;
   logic       load;

   assign load = head_valid && (!valid_ff || rsp_ch.ready);

   // Pick the next result word out of the head entry.
   always_comb begin
      phase_in = phase_ff;
      char_in  = char_ff;
      cv_in    = cv_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      valid_in = valid_ff && !rsp_ch.ready;
      if (load) begin
         valid_in = 1'b1;
         if (phase_ff == PH_FIRST && head_job.pre_valid) begin
            char_in  = head_job.pre_char;
            cv_in    = 1'b1;
            last_in  = !head_job.main_valid;
            pop      = !head_job.main_valid;
            phase_in = head_job.main_valid ? PH_SECOND : PH_FIRST;
         end else if (head_job.main_valid) begin
            char_in  = head_job.main_char;
            cv_in    = 1'b1;
            last_in  = 1'b1;
            pop      = 1'b1;
            phase_in = PH_FIRST;
         end else begin
            char_in  = 8'h00;
            cv_in    = 1'b0;
            last_in  = 1'b1;
            pop      = 1'b1;
            phase_in = PH_FIRST;
         end
      end
   end

   // Output register; status fields come straight from the head entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
         char_ff  <= char_in;
         cv_ff    <= cv_in;
         last_ff  <= last_in;
         if (load) begin
            rsp_ch.indicators     <= head_job.indicators;
            rsp_ch.bell_request   <= head_job.bell_request;
            rsp_ch.reset_request  <= head_job.reset_request;
            rsp_ch.print_start    <= head_job.print_start;
            rsp_ch.print_positive <= head_job.print_positive;
         end
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.char_out   = char_ff;
   assign rsp_ch.char_valid = cv_ff;
   assign rsp_ch.last       = last_ff;

   `KBD_ASSERT_IMP(a_second_has_head, clock, reset, phase_ff == PH_SECOND, head_valid, "second character without a queued entry")
   `KBD_ASSERT_IMP(a_empty_is_last, clock, reset, valid_ff && !cv_ff, last_ff, "empty result not marked last")
   `KBD_ASSERT_IMP(a_req_no_char, clock, reset, valid_ff && (rsp_ch.bell_request || rsp_ch.reset_request || rsp_ch.print_start), !cv_ff, "request together with a character")

endmodule

`default_nettype wire

[rtl/keyboard_scan_code_translator.sv]
// Keyboard scan code translator. Each scan code word on req_ch is looked up in a fixed key table
// and, together with the shift, ctrl, fix and cyrillic state, yields one or two result words on
// rsp_ch: a result per character, or a single result with char_valid low when the code gives no
// character; the final one carries last. The front accepts one scan code per cycle while the
// queue is not full and updates the keyboard state at once; a small queue (QUEUE_DEPTH entries)
// feeds the output register, which delivers one result per cycle while rsp_ch.ready is high, so
// a scan code takes one result word at the output, or two when it yields two characters. An
// accepted scan code is written into the queue and then loaded into the output register, which
// offers its first result. The csr_ port writes stop_char (0), start_char (1), raw_mode (2),
// restart_on_start_only (3) and alt_keypad (4); write them only while no scan code is in flight.
`default_nettype none

module keyboard_scan_code_translator import kbd_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   kbd_req_if.sink                req_ch,
   kbd_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   kbd_cfg_type cfg_ff;
   kbd_job_type push_job;
   kbd_job_type head_job;
   logic        push;
   logic        pop;
   logic        full;
   logic        head_valid;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_char             <= STOP_CHAR_RESET;
         cfg_ff.start_char            <= START_CHAR_RESET;
         cfg_ff.raw_mode              <= 1'b0;
         cfg_ff.restart_on_start_only <= 1'b0;
         cfg_ff.alt_keypad            <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STOP_CHAR:    cfg_ff.stop_char             <= csr_wdata;
            CSR_START_CHAR:   cfg_ff.start_char            <= csr_wdata;
            CSR_RAW_MODE:     cfg_ff.raw_mode              <= csr_wdata[0];
            CSR_RESTART_ONLY: cfg_ff.restart_on_start_only <= csr_wdata[0];
            CSR_ALT_KEYPAD:   cfg_ff.alt_keypad            <= csr_wdata[0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   kbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .queue_full (full),
      .job_push   (push),
      .job        (push_job)
   );

   kbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   kbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import kbd_pkg::*;

   localparam int CLOCK_PERIOD     = 10;
   localparam int RESET_CYCLES     = 10;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int TIMEOUT_CYCLES   = 800_000;

   // Scan codes that the directed part and the random bursts name.
   localparam logic [7:0] FIRST_CODE  = 8'o126;
   localparam logic [7:0] KEY_HOLD    = 8'd86;
   localparam logic [7:0] KEY_PRINT   = 8'd87;
   localparam logic [7:0] KEY_ESC_F   = 8'd88;
   localparam logic [7:0] KEY_KP_0    = 8'd146;
   localparam logic [7:0] KEY_SHIFT   = 8'd174;
   localparam logic [7:0] KEY_CTRL    = 8'd175;
   localparam logic [7:0] KEY_FIX     = 8'd176;
   localparam logic [7:0] KEY_SCROLL  = 8'd177;
   localparam logic [7:0] KEY_RUS     = 8'd178;
   localparam logic [7:0] KEY_RELEASE = 8'd179;
   localparam logic [7:0] KEY_REPEAT  = 8'd180;
   localparam logic [7:0] KEY_DIGIT_1 = 8'd192;
   localparam logic [7:0] KEY_A       = 8'd210;
   localparam logic [7:0] KEY_UNDER   = 8'd241;
   localparam logic [7:0] KEY_CYR     = 8'd253;
   localparam logic [7:0] KEY_TOP     = 8'd255;
   localparam logic [7:0] MODIFIER_KEYS [0:8] = '{KEY_HOLD, KEY_PRINT, KEY_SHIFT, KEY_CTRL,
      KEY_FIX, KEY_SCROLL, KEY_RUS, KEY_RELEASE, KEY_REPEAT};

   // Key table from code 0126 up: class in bits 10:8, character in bits 7:0.
   localparam logic [10:0] NO_KEY = 11'd0;
   localparam logic [10:0] KEY_TABLE [0:169] = '{
      // 0126
      {CLS_SPEC, 1'b0, SP_HOLD}, {CLS_SPEC, 1'b0, SP_PRSC},
      {CLS_ESC, 8'h46}, {CLS_ESC, 8'h47}, {CLS_ESC, 8'h48},
      NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY,
      // 0140
      NO_KEY, NO_KEY, NO_KEY, NO_KEY,
      {CLS_ESC, 8'h49}, {CLS_ESC, 8'h4A}, {CLS_ESC, 8'h4B}, {CLS_ESC, 8'h4C},
      {CLS_ESC, 8'h4D}, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY, NO_KEY,
      NO_KEY, {CLS_ESC, 8'h4E}, {CLS_ESC, 8'h4F}, {CLS_ESC, 8'h50},
      {CLS_ESC, 8'h51}, NO_KEY, NO_KEY, NO_KEY,
      NO_KEY, NO_KEY, NO_KEY, NO_KEY, {CLS_ESC, 8'h52}, {CLS_ESC, 8'h53}, NO_KEY, NO_KEY,
      // 0200
      {CLS_ESC, 8'h54}, {CLS_ESC, 8'h55}, {CLS_ESC, 8'h56}, {CLS_ESC, 8'h57},
      NO_KEY, NO_KEY, NO_KEY, NO_KEY,
      NO_KEY, NO_KEY, {CLS_ESC, 8'h58}, {CLS_ESC, 8'h59},
      {CLS_ESC, 8'h5A}, {CLS_ESC, 8'h40}, {CLS_ESC, 8'h30}, {CLS_ESC, 8'h31},
      NO_KEY, NO_KEY, {CLS_KPAD, 8'h30}, NO_KEY,
      {CLS_KPAD, 8'h2E}, {CLS_LIT, 8'h0A}, {CLS_KPAD, 8'h31}, {CLS_KPAD, 8'h32},
      {CLS_KPAD, 8'h33}, {CLS_KPAD, 8'h34}, {CLS_KPAD, 8'h35}, {CLS_KPAD, 8'h36},
      {CLS_KPAD, 8'h2C}, {CLS_KPAD, 8'h37}, {CLS_KPAD, 8'h38}, {CLS_KPAD, 8'h39},
      // 0240
      {CLS_KPAD, 8'h2D}, {CLS_ESC, 8'h32}, {CLS_ESC, 8'h33}, {CLS_ESC, 8'h34},
      {CLS_ESC, 8'h35}, NO_KEY, NO_KEY, {CLS_ESC, 8'h36},
      {CLS_ESC, 8'h37}, {CLS_ESC, 8'h38}, {CLS_ESC, 8'h39}, NO_KEY,
      NO_KEY, NO_KEY, {CLS_SPEC, 1'b0, SP_SHF}, {CLS_SPEC, 1'b0, SP_CTRL},
      {CLS_SPEC, 1'b0, SP_FIX}, {CLS_SPEC, 1'b0, SP_SCRL}, {CLS_SPEC, 1'b0, SP_RUS},
      {CLS_SPEC, 1'b0, SP_ROFF}, {CLS_SPEC, 1'b0, SP_RPT}, NO_KEY, NO_KEY, NO_KEY,
      NO_KEY, NO_KEY, NO_KEY, NO_KEY,
      {CLS_LIT, 8'h7F}, {CLS_LIT, 8'h0D}, {CLS_LIT, 8'h09}, {CLS_DIG, 8'h2B},
      // 0300
      {CLS_DIG, 8'h21}, {CLS_PLAIN, 8'h6A}, {CLS_PLAIN, 8'h66}, {CLS_PLAIN, 8'h71},
      {CLS_LIT, 8'h08}, {CLS_DIG, 8'h22}, {CLS_PLAIN, 8'h63}, {CLS_PLAIN, 8'h79},
      {CLS_PLAIN, 8'h7E}, {CLS_ESC, 8'h42}, {CLS_DIG, 8'h3F}, {CLS_DIG, 8'h23},
      {CLS_PLAIN, 8'h75}, {CLS_PLAIN, 8'h77}, {CLS_PLAIN, 8'h73}, NO_KEY,
      {CLS_DIG, 8'h24}, {CLS_PLAIN, 8'h6B}, {CLS_PLAIN, 8'h61}, {CLS_PLAIN, 8'h6D},
      {CLS_LIT, 8'h20}, NO_KEY, {CLS_DIG, 8'h25}, {CLS_PLAIN, 8'h65},
      {CLS_PLAIN, 8'h70}, {CLS_PLAIN, 8'h69}, NO_KEY, {CLS_DIG, 8'h26},
      {CLS_PLAIN, 8'h6E}, {CLS_PLAIN, 8'h72}, {CLS_PLAIN, 8'h74}, NO_KEY,
      // 0340
      {CLS_DIG, 8'h27}, {CLS_PLAIN, 8'h67}, {CLS_PLAIN, 8'h6F}, {CLS_PLAIN, 8'h78},
      NO_KEY, {CLS_DIG, 8'h28}, {CLS_PLAIN, 8'h7B}, {CLS_PLAIN, 8'h6C},
      {CLS_PLAIN, 8'h62}, NO_KEY, {CLS_DIG, 8'h29}, {CLS_PLAIN, 8'h7D},
      {CLS_PLAIN, 8'h64}, {CLS_PLAIN, 8'h60}, NO_KEY, {CLS_LIT, 8'h30},
      {CLS_PLAIN, 8'h7A}, {CLS_CTL, 8'h5F}, {CLS_PLAIN, 8'h76}, {CLS_DIG, 8'h3C},
      NO_KEY, {CLS_ESC, 8'h41}, {CLS_PLAIN, 8'h68}, {CLS_DIG, 8'h3E},
      NO_KEY, {CLS_DIG, 8'h3D}, {CLS_DIG, 8'h2A}, {CLS_PLAIN, 8'h7C},
      {CLS_ESC, 8'h43}, {CLS_CYR, 8'h5F}, NO_KEY, NO_KEY
   };

   typedef struct packed {
      logic [7:0] scan_code;
      logic       output_stopped;
      logic       queue_over_half;
      logic       print_waiting;
   } scan_word_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       char_valid;
      logic       last;
      logic [4:0] indicators;
      logic       bell_request;
      logic       reset_request;
      logic       print_start;
      logic       print_positive;
   } result_word_type;

   // How a produced character leaves: with the prefix cleared and the stop check
   // applied, or directly (after an escape or GS prefix, or on repeat).
   typedef enum logic [1:0] {EMIT_NONE, EMIT_CHECKED, EMIT_DIRECT} emit_kind_type;

   // Keyboard state mirror, translation of accepted scan codes and the queue of
   // result words still to come.
   class translation_board;
      logic [7:0]        stop_char, start_char;
      logic              raw_mode, restart_only, alt_keypad;
      logic              cyrillic_on, ctrl_on, fix_on;
      logic [1:0]        shift_level;
      logic signed [2:0] scroll_level;
      logic [7:0]        previous_char, previous_prefix;
      logic [4:0]        indicator_bits;
      result_word_type   expected_words [$];
      int                failures, scans_seen, keyed_scans, words_checked, chars_checked;

      function new();
         stop_char       = STOP_CHAR_RESET;
         start_char      = START_CHAR_RESET;
         raw_mode        = 1'b0;
         restart_only    = 1'b0;
         alt_keypad      = 1'b0;
         cyrillic_on     = 1'b0;
         ctrl_on         = 1'b0;
         fix_on          = 1'b0;
         shift_level     = '0;
         scroll_level    = '0;
         previous_char   = '0;
         previous_prefix = '0;
         indicator_bits  = '0;
         failures        = 0;
         scans_seen      = 0;
         keyed_scans     = 0;
         words_checked   = 0;
         chars_checked   = 0;
      endfunction

      function void set_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_STOP_CHAR:    stop_char = value;
            CSR_START_CHAR:   start_char = value;
            CSR_RAW_MODE:     raw_mode = value[0];
            CSR_RESTART_ONLY: restart_only = value[0];
            CSR_ALT_KEYPAD:   alt_keypad = value[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // Translate one accepted scan code and queue the words it must cause.
      function void note_scan(input scan_word_type w);
         logic [10:0]     entry;
         logic [7:0]      c1;
         logic [7:0]      chars [0:1];
         int              nch, count, level;
         emit_kind_type   emit;
         logic            bell, rst, pstart, ppos;
         result_word_type r;
         entry  = NO_KEY;
         c1     = '0;
         nch    = 0;
         emit   = EMIT_NONE;
         bell   = 1'b0;
         rst    = 1'b0;
         pstart = 1'b0;
         ppos   = 1'b0;
         chars[0] = '0;
         chars[1] = '0;
         scans_seen++;
         if (w.scan_code >= FIRST_CODE) begin
            entry = KEY_TABLE[w.scan_code - FIRST_CODE];
         end
         if (entry != NO_KEY) begin
            keyed_scans++;
            c1 = {1'b0, entry[6:0]};
            case (kbd_class_type'(entry[10:8]))
               CLS_CYR: begin
                  if (cyrillic_on) begin
                     emit = EMIT_CHECKED;
                  end else begin
                     previous_char   = '0;
                     previous_prefix = '0;
                  end
               end
               CLS_LIT: emit = EMIT_CHECKED;
               CLS_KPAD: begin
                  if (!alt_keypad) begin
                     emit = EMIT_CHECKED;
                  end else begin
                     previous_prefix = CHR_GS;
                     chars[nch] = CHR_GS;
                     nch++;
                     emit = EMIT_DIRECT;
                  end
               end
               CLS_ESC: begin
                  previous_prefix = CHR_ESC;
                  chars[nch] = CHR_ESC;
                  nch++;
                  emit = EMIT_DIRECT;
               end
               CLS_DIG: begin
                  if (shift_level == 0) c1 = c1 ^ CHR_DIG_BIT;
                  emit = EMIT_CHECKED;
               end
               CLS_PLAIN: begin
                  if (shift_level != 0) c1 = c1 ^ CHR_CASE_BIT;
                  if (fix_on) c1 = c1 ^ CHR_CASE_BIT;
                  if (ctrl_on) c1 = c1 & CHR_CTL_MASK;
                  emit = EMIT_CHECKED;
               end
               CLS_CTL: begin
                  if (ctrl_on) c1 = c1 & CHR_CTL_MASK;
                  emit = EMIT_CHECKED;
               end
               CLS_SPEC: begin
                  case (entry[6:0])
                     SP_SHF: begin
                        if (shift_level < 2) shift_level++;
                     end
                     SP_CTRL: begin
                        shift_level = '0;
                        ctrl_on     = 1'b1;
                     end
                     SP_ROFF: begin
                        if (ctrl_on) ctrl_on = 1'b0;
                        else if (shift_level != 0) shift_level--;
                     end
                     SP_FIX: begin
                        fix_on = !fix_on;
                        if (fix_on) indicator_bits = indicator_bits | IND_FIX;
                        else indicator_bits = indicator_bits & ~IND_FIX;
                     end
                     SP_RUS: begin
                        cyrillic_on = !cyrillic_on;
                        if (cyrillic_on) begin
                           chars[nch]     = CHR_SO;
                           indicator_bits = indicator_bits | IND_RUS;
                        end else begin
                           chars[nch]     = CHR_SI;
                           indicator_bits = indicator_bits & ~IND_RUS;
                        end
                        nch++;
                        previous_char   = '0;
                        previous_prefix = '0;
                     end
                     SP_RPT: begin
                        // Repeat is dropped while the input queues are over half full.
                        if (!w.queue_over_half) begin
                           if (previous_prefix != 0) begin
                              chars[nch] = previous_prefix;
                              nch++;
                           end
                           if (previous_char != 0) begin
                              c1   = previous_char;
                              emit = EMIT_DIRECT;
                           end
                        end
                     end
                     SP_SCRL: begin
                        // The emitted stop or start character skips the 0 and 0377 test.
                        level = int'(scroll_level);
                        if (shift_level != 0 || ctrl_on) begin
                           level--;
                           if (level < -1) level = -1;
                           if (level > 3) level = 3;
                           scroll_level = 3'(level);
                           if (w.output_stopped) begin
                              c1   = start_char;
                              emit = EMIT_CHECKED;
                           end
                        end else begin
                           level++;
                           if (level < -1) level = -1;
                           if (level > 3) begin
                              level = 3;
                              if (!w.output_stopped) begin
                                 c1   = stop_char;
                                 emit = EMIT_CHECKED;
                              end
                           end
                           scroll_level = 3'(level);
                        end
                     end
                     SP_HOLD: begin
                        if (ctrl_on && shift_level != 0) begin
                           rst  = 1'b1;
                           bell = 1'b1;
                        end else begin
                           c1 = w.output_stopped ? start_char : stop_char;
                           if (c1 != 0 && c1 != CHR_ALL_ONES) emit = EMIT_CHECKED;
                        end
                     end
                     SP_PRSC: begin
                        if (w.print_waiting) begin
                           pstart         = 1'b1;
                           ppos           = ctrl_on || shift_level != 0;
                           indicator_bits = indicator_bits | IND_WAIT;
                        end
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end

         // Flow control bookkeeping for the main character.
         if (emit == EMIT_CHECKED) begin
            previous_prefix = '0;
            if (c1 == stop_char && c1 != 0 && c1 != CHR_ALL_ONES && !raw_mode &&
                !w.output_stopped) begin
               indicator_bits = indicator_bits | IND_STOP;
            end
         end
         if (emit != EMIT_NONE) begin
            previous_char = c1;
            if (!raw_mode && w.output_stopped && (!restart_only || c1 == start_char)) begin
               indicator_bits = indicator_bits & ~(IND_STOP | IND_WAIT);
            end
            chars[nch] = c1;
            nch++;
         end

         count = (nch == 0) ? 1 : nch;
         for (int k = 0; k < count; k++) begin
            r.char_out       = (nch == 0) ? 8'h00 : chars[k];
            r.char_valid     = (nch != 0);
            r.last           = (k == count - 1);
            r.indicators     = indicator_bits;
            r.bell_request   = bell;
            r.reset_request  = rst;
            r.print_start    = pstart;
            r.print_positive = ppos;
            expected_words.push_back(r);
         end
      endfunction

      function void check_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
         if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      // Compare one delivered result word with the oldest one still expected.
      function void check_result(input result_word_type got);
         result_word_type want;
         if (expected_words.size() == 0) begin
            $error("result word with none expected: char_out 0x%0h", got.char_out);
            failures++;
            return;
         end
         want = expected_words.pop_front();
         check_field("char_out", want.char_out, got.char_out);
         check_field("char_valid", 8'(want.char_valid), 8'(got.char_valid));
         check_field("last", 8'(want.last), 8'(got.last));
         check_field("indicators", 8'(want.indicators), 8'(got.indicators));
         check_field("bell_request", 8'(want.bell_request), 8'(got.bell_request));
         check_field("reset_request", 8'(want.reset_request), 8'(got.reset_request));
         check_field("print_start", 8'(want.print_start), 8'(got.print_start));
         check_field("print_positive", 8'(want.print_positive), 8'(got.print_positive));
         words_checked++;
         if (got.char_valid) chars_checked++;
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   steady;
   int                     hold_off_requests;

   kbd_req_if req_ch ();
   kbd_rsp_if rsp_ch ();

   translation_board board = new();

   keyboard_scan_code_translator dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Mostly short idle stretches, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic scan_word_type scan(input logic [7:0] code, input logic stopped,
                                          input logic over_half, input logic waiting);
      scan_word_type w;
      w.scan_code       = code;
      w.output_stopped  = stopped;
      w.queue_over_half = over_half;
      w.print_waiting   = waiting;
      return w;
   endfunction

   function automatic scan_word_type random_scan(input logic [7:0] code);
      return scan(code, $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0,
                  $urandom_range(0, 2) == 0);
   endfunction

   // Mostly table keys, some modifier keys and a little noise below the table.
   function automatic logic [7:0] random_code();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 6) return 8'($urandom_range(0, FIRST_CODE - 1));
      if (roll < 22) return MODIFIER_KEYS[$urandom_range(0, 8)];
      return 8'($urandom_range(FIRST_CODE, KEY_TOP));
   endfunction

   // Offer one scan code word, after a random gap unless steady, and wait until it is taken.
   task automatic send_scan(input scan_word_type w);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid           = 1'b1;
      req_ch.scan_code       = w.scan_code;
      req_ch.output_stopped  = w.output_stopped;
      req_ch.queue_over_half = w.queue_over_half;
      req_ch.print_waiting   = w.print_waiting;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_scan(w);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_ch.valid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      board.set_register(index, value);
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] stop_value, input logic [7:0] start_value,
                                 input logic raw, input logic restart, input logic alt);
      write_register(CSR_STOP_CHAR, stop_value);
      write_register(CSR_START_CHAR, start_value);
      write_register(CSR_RAW_MODE, CSR_DATA_W'(raw));
      write_register(CSR_RESTART_ONLY, CSR_DATA_W'(restart));
      write_register(CSR_ALT_KEYPAD, CSR_DATA_W'(alt));
      csr_we = 1'b0;
   endtask

   // One random item, or a short well-formed key sequence with random content.
   task automatic send_random_burst();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
         send_scan(random_scan(random_code()));
      end else if (kind < 90) begin
         // Drop ctrl and shift, then scroll up until the stop character is due.
         repeat (3) send_scan(random_scan(KEY_RELEASE));
         repeat (5) send_scan(scan(KEY_SCROLL, $urandom_range(0, 3) == 0, 1'b0, 1'b0));
      end else if (kind < 95) begin
         send_scan(random_scan(8'($urandom_range(FIRST_CODE, KEY_TOP))));
         repeat (2) send_scan(random_scan(KEY_REPEAT));
      end else begin
         send_scan(random_scan(($urandom_range(0, 1) == 0) ? KEY_CTRL : KEY_SHIFT));
         send_scan(random_scan(KEY_SHIFT));
         send_scan(random_scan(($urandom_range(0, 1) == 0) ? KEY_HOLD : KEY_PRINT));
         repeat (2) send_scan(random_scan(KEY_RELEASE));
      end
   endtask

   // Random phase: a stretch without idling (with the long receiver hold-off if
   // asked), and a pause until every result word has come if asked.
   task automatic run_random(input int scan_target, input bit hold_off, input bit pause);
      int first_scans, done, stage;
      first_scans = board.scans_seen;
      stage       = 0;
      done        = 0;
      while (done < scan_target) begin
         if (stage == 0 && done >= scan_target / 4) begin
            stage  = 1;
            steady = 1'b1;
            if (hold_off) hold_off_requests++;
         end else if (stage == 1 && done >= scan_target / 4 + 40) begin
            stage  = 2;
            steady = 1'b0;
         end else if (stage == 2 && done >= scan_target / 2) begin
            stage = 3;
            if (pause) wait_for_results();
         end
         send_random_burst();
         done = board.scans_seen - first_scans;
      end
      steady = 1'b0;
      wait_for_results();
   endtask

   // Result side: random ready gaps, plus the long hold-off when requested.
   initial begin : result_sink
      int gap_left, stall_left, hold_offs_served;
      gap_left         = 0;
      stall_left       = 0;
      hold_offs_served = 0;
      rsp_ch.ready     = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_offs_served != hold_off_requests) begin
            hold_offs_served++;
            stall_left = LONG_HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else if (steady) begin
            rsp_ch.ready = 1'b1;
         end else if (gap_left > 0) begin
            rsp_ch.ready = 1'b0;
            gap_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            if ($urandom_range(0, 3) == 0) gap_left = pick_gap();
         end
      end
   end

   // Every result word taken by the sink is checked at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_result({rsp_ch.char_out, rsp_ch.char_valid, rsp_ch.last,
                             rsp_ch.indicators, rsp_ch.bell_request, rsp_ch.reset_request,
                             rsp_ch.print_start, rsp_ch.print_positive});
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      scan_word_type directed_scans [$];
      reset                  = 1'b1;
      steady                 = 1'b0;
      hold_off_requests      = 0;
      csr_we                 = 1'b0;
      csr_index              = '0;
      csr_wdata              = '0;
      req_ch.valid           = 1'b0;
      req_ch.scan_code       = '0;
      req_ch.output_stopped  = 1'b0;
      req_ch.queue_over_half = 1'b0;
      req_ch.print_waiting   = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset settings: codes outside the table, case and
      // ctrl handling, shift saturation, hold with and without ctrl+shift, print
      // screen, escape prefix, keypad key, cyrillic keys, repeat and scroll.
      directed_scans.push_back(scan(8'h00, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(8'(FIRST_CODE - 1), 1'b1, 1'b1, 1'b1));
      directed_scans.push_back(scan(KEY_TOP, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_A, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_SHIFT, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_SHIFT, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_SHIFT, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_A, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_DIGIT_1, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_CTRL, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_A, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_UNDER, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_HOLD, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_SHIFT, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_HOLD, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_PRINT, 1'b0, 1'b0, 1'b1));
      directed_scans.push_back(scan(KEY_RELEASE, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_RELEASE, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_FIX, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_DIGIT_1, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_ESC_F, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_KP_0, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_CYR, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_RUS, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_CYR, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_REPEAT, 1'b0, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_REPEAT, 1'b0, 1'b1, 1'b0));
      directed_scans.push_back(scan(KEY_SCROLL, 1'b1, 1'b0, 1'b0));
      directed_scans.push_back(scan(KEY_HOLD, 1'b1, 1'b0, 1'b0));
      foreach (directed_scans[i]) send_scan(directed_scans[i]);
      wait_for_results();

      run_random(300, 1'b1, 1'b0);
      apply_settings(8'h00, 8'hFF, 1'b1, 1'b1, 1'b1);
      run_random(250, 1'b0, 1'b1);
      apply_settings(8'hFF, 8'h00, 1'b0, 1'b0, 1'b1);
      run_random(250, 1'b0, 1'b0);
      // Flow characters that ordinary letters produce, so typing hits them.
      apply_settings(8'h61, 8'h71, 1'b0, 1'b1, 1'b0);
      run_random(300, 1'b1, 1'b0);
      apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_random(300, 1'b0, 1'b1);

      wait_for_results();
      repeat (20) @(posedge clock);
      $display("Translated %0d scan codes (%0d table keys) into %0d result words, %0d chars,",
               board.scans_seen, board.keyed_scans, board.words_checked, board.chars_checked);
      $display("across five register settings including zero and all-ones flow characters.");
      if (board.failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
